// File: hw/rtl/bgc_pkg.sv
// Shared types, codes and reset constants for the button gesture classifier.
// No dependencies; every other file but bgc_if imports this package.
`default_nettype none

package bgc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int THR_BITS      = 16;
	localparam int IDX_BITS      = 3;

	// Configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		CFG_POLARITY    = 3'd0,
		CFG_DEBOUNCE    = 3'd1,
		CFG_WINDOW      = 3'd2,
		CFG_LONG_ONE    = 3'd3,
		CFG_LONG_TWO    = 3'd4,
		CFG_LONG_THREE  = 3'd5,
		CFG_LONG_FOUR   = 3'd6
	} cfg_idx_t;

	localparam logic [THR_BITS-1:0] RST_DEBOUNCE   = 16'd50;
	localparam logic [THR_BITS-1:0] RST_WINDOW     = 16'd300;
	localparam logic [THR_BITS-1:0] RST_LONG_ONE   = 16'd2000;
	localparam logic [THR_BITS-1:0] RST_LONG_TWO   = 16'd4000;
	localparam logic [THR_BITS-1:0] RST_LONG_THREE = 16'd6000;
	localparam logic [THR_BITS-1:0] RST_LONG_FOUR  = 16'd10000;

	// Gesture action codes
	localparam logic [3:0] ACT_IDLE   = 4'd0;
	localparam logic [3:0] ACT_SINGLE = 4'd1;
	localparam logic [3:0] ACT_TRIPLE = 4'd3;
	localparam logic [3:0] ACT_QUAD   = 4'd4;
	localparam logic [3:0] ACT_LONG1  = 4'd5;
	localparam logic [3:0] ACT_LONG2  = 4'd6;
	localparam logic [3:0] ACT_LONG3  = 4'd7;
	localparam logic [3:0] ACT_LONG4  = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE        = 4'd0,
		ST_PRESS_DB    = 4'd1,
		ST_HELD        = 4'd2,
		ST_REL_DB      = 4'd3,
		ST_WAIT        = 4'd4,
		ST_NEXT_DB     = 4'd5,
		ST_NEXT_HELD   = 4'd6,
		ST_NEXT_REL_DB = 4'd7,
		ST_DONE_DB     = 4'd8
	} step_t;

	typedef struct packed {
		logic                pressed_high;
		logic [THR_BITS-1:0] debounce;
		logic [THR_BITS-1:0] window;
		logic [THR_BITS-1:0] long_one;
		logic [THR_BITS-1:0] long_two;
		logic [THR_BITS-1:0] long_three;
		logic [THR_BITS-1:0] long_four;
	} cfg_t;

	typedef struct packed {
		logic pin_level;
		logic clear_request;
		logic wake_press;
	} sample_t;

	typedef struct packed {
		logic       gesture_done;
		logic [3:0] gesture_code;
		logic [2:0] click_count;
		logic [3:0] machine_state;
	} result_t;

	typedef struct packed {
		logic  finished;
		step_t step;
	} core_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/bgc_if.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
// Widths are written out here and match those in bgc_pkg.
`default_nettype none

interface bgc_sample_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic clear_request;
	logic wake_press;

	modport source (output valid, output pin_level, output clear_request,
		output wake_press, input ready);
	modport sink (input valid, input pin_level, input clear_request,
		input wake_press, output ready);
endinterface

interface bgc_result_if;
	logic       valid;
	logic       ready;
	logic       gesture_done;
	logic [3:0] gesture_code;
	logic [2:0] click_count;
	logic [3:0] machine_state;

	modport source (output valid, output gesture_done, output gesture_code,
		output click_count, output machine_state, input ready);
	modport sink (input valid, input gesture_done, input gesture_code,
		input click_count, input machine_state, output ready);
endinterface

interface bgc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bgc_cfg_regs.sv
// Configuration register file for the gesture classifier.
// Depends on bgc_pkg; writes to unknown indexes are dropped.
`default_nettype none

module bgc_cfg_regs
	import bgc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [IDX_BITS-1:0] index,
	input  logic [THR_BITS-1:0] data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressed_high <= 1'b1;
			cfg_q.debounce     <= RST_DEBOUNCE;
			cfg_q.window       <= RST_WINDOW;
			cfg_q.long_one     <= RST_LONG_ONE;
			cfg_q.long_two     <= RST_LONG_TWO;
			cfg_q.long_three   <= RST_LONG_THREE;
			cfg_q.long_four    <= RST_LONG_FOUR;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_POLARITY:    cfg_q.pressed_high <= data[0];
				CFG_DEBOUNCE:    cfg_q.debounce     <= data;
				CFG_WINDOW:      cfg_q.window       <= data;
				CFG_LONG_ONE:    cfg_q.long_one     <= data;
				CFG_LONG_TWO:    cfg_q.long_two     <= data;
				CFG_LONG_THREE:  cfg_q.long_three   <= data;
				CFG_LONG_FOUR:   cfg_q.long_four    <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/bgc_core.sv
// Classifier state and per-sample update: tick clock, edge flags, press and
// release times, step machine, action and finished flag. Depends on bgc_pkg.
`default_nettype none

module bgc_core
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  sample_t      smp,
	input  cfg_t         cfg,
	output result_t      res,
	output core_status_t st
);

	typedef logic [TIME_BITS-1:0] tick_t;

	tick_t      tick_q, pstart_q, rstart_q;
	logic       prev_q, rise_q, fall_q, fin_q;
	step_t      step_q;
	logic [3:0] act_q;

	// values after clear, wake and edge detection
	logic       lvl;
	logic       rise_w, fall_w, fin_w;
	step_t      step_w;
	logic [3:0] act_w;
	tick_t      pstart_w;
	tick_t      since_press, since_rel;
	logic       db_press, db_rel, win_over, rel_cond, is_long;
	logic       g1, g2, g3, g4;

	// next values
	step_t      step_n;
	logic [3:0] act_n;
	logic       rise_n, fall_n, fin_n;
	tick_t      pstart_n, rstart_n;

	always_comb begin
		lvl      = smp.pin_level ^ ~cfg.pressed_high;
		rise_w   = smp.clear_request ? 1'b0 : rise_q;
		fall_w   = smp.clear_request ? 1'b0 : fall_q;
		fin_w    = smp.clear_request ? 1'b0 : fin_q;
		step_w   = smp.clear_request ? ST_IDLE : step_q;
		act_w    = smp.clear_request ? ACT_IDLE : act_q;
		pstart_w = pstart_q;
		if (smp.wake_press) begin
			act_w    = ACT_SINGLE;
			step_w   = ST_HELD;
			pstart_w = tick_q;
		end
		if (lvl != prev_q) begin
			if (lvl) begin
				rise_w = 1'b1;
			end else begin
				fall_w = 1'b1;
			end
		end
		since_press = tick_q - pstart_w;
		since_rel   = tick_q - rstart_q;
		db_press    = since_press >= tick_t'(cfg.debounce);
		db_rel      = since_rel >= tick_t'(cfg.debounce);
		win_over    = since_press >= tick_t'(cfg.window);
		rel_cond    = fall_w || !lvl;
		is_long     = act_w inside {[ACT_LONG1:ACT_LONG4]};
		g1 = since_press >= tick_t'(cfg.long_one);
		g2 = since_press >= tick_t'(cfg.long_two);
		g3 = since_press >= tick_t'(cfg.long_three);
		g4 = since_press >= tick_t'(cfg.long_four);
	end

	// next step
	always_comb begin
		step_n = step_w;
		if (!fin_w) begin
			case (step_w)
				ST_IDLE: begin
					if (rise_w) step_n = ST_PRESS_DB;
				end
				ST_PRESS_DB: begin
					if (db_press) step_n = lvl ? ST_HELD : ST_IDLE;
				end
				ST_HELD: begin
					if (rel_cond) begin
						if (act_w == ACT_SINGLE) step_n = ST_REL_DB;
						else if (is_long) step_n = ST_DONE_DB;
					end
				end
				ST_REL_DB, ST_NEXT_REL_DB: begin
					if (db_rel) step_n = ST_WAIT;
				end
				ST_WAIT: begin
					if (rise_w) step_n = ST_NEXT_DB;
					else if (win_over) step_n = ST_IDLE;
				end
				ST_NEXT_DB: begin
					if (db_press) step_n = lvl ? ST_NEXT_HELD : ST_DONE_DB;
				end
				ST_NEXT_HELD: begin
					if (!lvl) step_n = ST_NEXT_REL_DB;
				end
				ST_DONE_DB: begin
					if (db_rel) step_n = ST_IDLE;
				end
				default: ;
			endcase
		end
	end

	// action, flags and time stamps
	always_comb begin
		act_n    = act_w;
		rise_n   = rise_w;
		fall_n   = fall_w;
		fin_n    = fin_w;
		pstart_n = pstart_w;
		rstart_n = rstart_q;
		if (!fin_w) begin
			case (step_w)
				ST_IDLE: begin
					if (rise_w) begin
						rise_n   = 1'b0;
						pstart_n = tick_q;
					end
				end
				ST_PRESS_DB: begin
					if (db_press && lvl) act_n = ACT_SINGLE;
				end
				ST_HELD: begin
					if (rel_cond) begin
						fall_n = 1'b0;
						if (act_w == ACT_SINGLE) begin
							rstart_n = tick_q;
						end else if (is_long) begin
							fin_n    = 1'b1;
							rstart_n = tick_q;
						end
					end
					// hold grading, tested in this order
					if (g1 && !g2) act_n = ACT_LONG1;
					else if (g2 && !g3) act_n = ACT_LONG2;
					else if (g3 && !g4) act_n = ACT_LONG3;
					else if (g4) act_n = ACT_LONG4;
				end
				ST_WAIT: begin
					if (rise_w) begin
						rise_n   = 1'b0;
						pstart_n = tick_q;
					end else if (win_over) begin
						fin_n = 1'b1;
					end
				end
				ST_NEXT_DB: begin
					if (db_press) begin
						if (lvl) begin
							if (act_w inside {[ACT_SINGLE:ACT_TRIPLE]}) act_n = act_w + 4'd1;
						end else begin
							fin_n    = 1'b1;
							rstart_n = tick_q;
						end
					end
				end
				ST_NEXT_HELD: begin
					if (!lvl) rstart_n = tick_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			pstart_q <= '0;
			rstart_q <= '0;
			prev_q   <= 1'b0;
			rise_q   <= 1'b0;
			fall_q   <= 1'b0;
			fin_q    <= 1'b0;
			step_q   <= ST_IDLE;
			act_q    <= ACT_IDLE;
		end else if (accept) begin
			tick_q   <= tick_q + tick_t'(1);
			pstart_q <= pstart_n;
			rstart_q <= rstart_n;
			prev_q   <= lvl;
			rise_q   <= rise_n;
			fall_q   <= fall_n;
			fin_q    <= fin_n;
			step_q   <= step_n;
			act_q    <= act_n;
		end
	end

	always_comb begin
		res.gesture_done  = fin_n;
		res.gesture_code  = act_n;
		res.click_count   = (act_n inside {[ACT_SINGLE:ACT_QUAD]}) ? act_n[2:0] : 3'd0;
		res.machine_state = step_n;
	end

	assign st.finished = fin_q;
	assign st.step     = step_q;

endmodule

`default_nettype wire

// File: hw/rtl/button_gesture_classifier.sv
// Top level of the button gesture classifier: config registers, classifier
// core and result register. Depends on bgc_pkg, bgc_if, bgc_cfg_regs, bgc_core.
`default_nettype none

// One pin sample per clock; each sample gives exactly one result, in the cycle
// after its transaction, from a result register. The whole state update
// (clear, wake, edge flags, step machine, time compares) is combinational,
// so samples are taken back to back as long as the result side keeps up;
// sample.ready drops only while the result register holds an untaken result
// and result.ready is low. Register writes are always ready and take effect
// on the next sample.
module button_gesture_classifier
	import bgc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bgc_sample_if.sink    sample,
	bgc_result_if.source  result,
	bgc_cfg_if.sink       cfg
);

	cfg_t         cfg_val;
	sample_t      smp;
	result_t      res_next, res_q;
	core_status_t core_st;
	logic         accept;
	logic         valid_q;

	assign cfg.ready = 1'b1;

	bgc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg.valid),
		.index  (cfg.index),
		.data   (cfg.data),
		.cfg    (cfg_val)
	);

	assign smp.pin_level     = sample.pin_level;
	assign smp.clear_request = sample.clear_request;
	assign smp.wake_press    = sample.wake_press;

	assign sample.ready = !valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	bgc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.smp    (smp),
		.cfg    (cfg_val),
		.res    (res_next),
		.st     (core_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res_next;
	end

	assign result.valid         = valid_q;
	assign result.gesture_done  = res_q.gesture_done;
	assign result.gesture_code  = res_q.gesture_code;
	assign result.click_count   = res_q.click_count;
	assign result.machine_state = res_q.machine_state;

	// every accepted sample lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid && result.machine_state == $past(res_next.machine_state))
		else $error("result register not loaded on sample transaction");

	// click count only accompanies click codes
	a_click_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.click_count != 3'd0 |->
			result.gesture_code == {1'b0, result.click_count})
		else $error("click count disagrees with gesture code");

	// frozen machine: without clear or wake the step holds while finished
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		accept && core_st.finished && !sample.clear_request && !sample.wake_press
			|=> core_st.step == $past(core_st.step) && core_st.finished)
		else $error("step moved while gesture finished");

	// a gesture finishes only from the held, window or second-press steps
	a_finish_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(core_st.finished) |->
			$past(core_st.step) == ST_HELD || $past(core_st.step) == ST_WAIT ||
			$past(core_st.step) == ST_NEXT_DB || $past(core_st.finished))
		else $error("finished flag set from unexpected step");

endmodule

`default_nettype wire

// File: tb/sv/bgc_gesture_check.sv
`timescale 1ns / 1ps
// Gesture checker: watches the sample, result and register-write channels,
// predicts every result and compares it field by field. Uses bgc_pkg, bgc_if.
module bgc_gesture_check
	import bgc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	bgc_sample_if sample_mon,
	bgc_result_if result_mon,
	bgc_cfg_if    cfg_mon,
	output int    fail_count,
	output int    owed_count
);

	cfg_t                     settings;
	logic [TIME_BITS_DEF-1:0] tick_now;
	logic [TIME_BITS_DEF-1:0] press_t;
	logic [TIME_BITS_DEF-1:0] release_t;
	logic                     prev_pressed;
	logic                     rise_flag;
	logic                     fall_flag;
	logic                     finished;
	step_t                    step;
	logic [3:0]               action;
	result_t                  expected_gestures[$];
	int                       fails = 0;

	task automatic report(input string field, input int want, input int got);
		fails++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// One tick of the classifier; updates the predicted state in place.
	task automatic classify_tick(input logic pin, input logic clr, input logic wake,
		output result_t r);
		logic                     pressed;
		logic [TIME_BITS_DEF-1:0] now;
		logic [TIME_BITS_DEF-1:0] since_press;
		logic [TIME_BITS_DEF-1:0] since_rel;
		now = tick_now;
		pressed = settings.pressed_high ? pin : ~pin;
		if (clr) begin
			rise_flag = 1'b0;
			fall_flag = 1'b0;
			finished = 1'b0;
			step = ST_IDLE;
			action = ACT_IDLE;
		end
		if (wake) begin
			action = ACT_SINGLE;
			step = ST_HELD;
			press_t = now;
		end
		if (pressed != prev_pressed) begin
			if (pressed)
				rise_flag = 1'b1;
			else
				fall_flag = 1'b1;
		end
		prev_pressed = pressed;

		if (!finished) begin
			since_press = now - press_t;
			since_rel = now - release_t;
			case (step)
				ST_IDLE: begin
					if (rise_flag) begin
						rise_flag = 1'b0;
						press_t = now;
						step = ST_PRESS_DB;
					end
				end
				ST_PRESS_DB: begin
					if (since_press >= settings.debounce) begin
						if (pressed) begin
							action = ACT_SINGLE;
							step = ST_HELD;
						end else begin
							step = ST_IDLE;
						end
					end
				end
				ST_HELD: begin
					if (fall_flag || !pressed) begin
						fall_flag = 1'b0;
						if (action == ACT_SINGLE) begin
							release_t = now;
							step = ST_REL_DB;
						end else if (action >= ACT_LONG1 && action <= ACT_LONG4) begin
							finished = 1'b1;
							release_t = now;
							step = ST_DONE_DB;
						end
					end
					// grading runs even on the tick that leaves the held step
					if (since_press >= settings.long_one && since_press < settings.long_two)
						action = ACT_LONG1;
					else if (since_press >= settings.long_two &&
						since_press < settings.long_three)
						action = ACT_LONG2;
					else if (since_press >= settings.long_three &&
						since_press < settings.long_four)
						action = ACT_LONG3;
					else if (since_press >= settings.long_four)
						action = ACT_LONG4;
				end
				ST_REL_DB, ST_NEXT_REL_DB: begin
					if (since_rel >= settings.debounce)
						step = ST_WAIT;
				end
				ST_WAIT: begin
					if (rise_flag) begin
						rise_flag = 1'b0;
						press_t = now;
						step = ST_NEXT_DB;
					end else if (since_press >= settings.window) begin
						finished = 1'b1;
						step = ST_IDLE;
					end
				end
				ST_NEXT_DB: begin
					if (since_press >= settings.debounce) begin
						if (pressed) begin
							if (action >= ACT_SINGLE && action <= ACT_TRIPLE)
								action = action + 4'd1;
							step = ST_NEXT_HELD;
						end else begin
							finished = 1'b1;
							release_t = now;
							step = ST_DONE_DB;
						end
					end
				end
				ST_NEXT_HELD: begin
					if (!pressed) begin
						release_t = now;
						step = ST_NEXT_REL_DB;
					end
				end
				ST_DONE_DB: begin
					if (since_rel >= settings.debounce)
						step = ST_IDLE;
				end
				default: ;
			endcase
		end
		tick_now = now + 1'b1;

		r.gesture_done = finished;
		r.gesture_code = action;
		r.click_count = (action >= ACT_SINGLE && action <= ACT_QUAD) ? action[2:0] : 3'd0;
		r.machine_state = step;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			settings = '{1'b1, RST_DEBOUNCE, RST_WINDOW, RST_LONG_ONE, RST_LONG_TWO,
				RST_LONG_THREE, RST_LONG_FOUR};
			tick_now = '0;
			press_t = '0;
			release_t = '0;
			prev_pressed = 1'b0;
			rise_flag = 1'b0;
			fall_flag = 1'b0;
			finished = 1'b0;
			step = ST_IDLE;
			action = ACT_IDLE;
			expected_gestures.delete();
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				got = '{result_mon.gesture_done, result_mon.gesture_code,
					result_mon.click_count, result_mon.machine_state};
				if (expected_gestures.size() == 0) begin
					fails++;
					$display("%0t: result transaction with nothing expected, actual %h",
						$time, got);
				end else begin
					want = expected_gestures.pop_front();
					if (got.gesture_done !== want.gesture_done)
						report("gesture_done", want.gesture_done, got.gesture_done);
					if (got.gesture_code !== want.gesture_code)
						report("gesture_code", want.gesture_code, got.gesture_code);
					if (got.click_count !== want.click_count)
						report("click_count", want.click_count, got.click_count);
					if (got.machine_state !== want.machine_state)
						report("machine_state", want.machine_state, got.machine_state);
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_idx_t'(cfg_mon.index))
					CFG_POLARITY:    settings.pressed_high = cfg_mon.data[0];
					CFG_DEBOUNCE:    settings.debounce = cfg_mon.data;
					CFG_WINDOW:      settings.window = cfg_mon.data;
					CFG_LONG_ONE:    settings.long_one = cfg_mon.data;
					CFG_LONG_TWO:    settings.long_two = cfg_mon.data;
					CFG_LONG_THREE:  settings.long_three = cfg_mon.data;
					CFG_LONG_FOUR:   settings.long_four = cfg_mon.data;
					default: ;
				endcase
			end
			if (sample_mon.valid && sample_mon.ready) begin
				classify_tick(sample_mon.pin_level, sample_mon.clear_request,
					sample_mon.wake_press, want);
				expected_gestures.push_back(want);
			end
		end
		fail_count <= fails;
		owed_count <= expected_gestures.size();
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for button_gesture_classifier: clock, reset, register writes,
// pin-sample stimulus and verdict. Uses bgc_pkg, bgc_if and bgc_gesture_check.
module tb;
	import bgc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 60;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int TAIL_CYCLES     = 8;

	logic clk = 1'b0;
	logic arst_n;

	bgc_sample_if sample_bus ();
	bgc_result_if result_bus ();
	bgc_cfg_if    cfg_bus ();

	int   gesture_fails;
	int   gestures_owed;
	int   ticks_sent = 0;
	int   span_cap = 100;
	bit   calm = 1'b0;
	bit   hold_request = 1'b0;
	cfg_t knobs;

	// pin, clear, wake; written for active-high polarity
	sample_t opening [25] = '{
		3'b000, 3'b100, 3'b100, 3'b100, 3'b000, 3'b000, 3'b000, 3'b101,
		3'b010, 3'b100, 3'b100, 3'b100, 3'b100, 3'b000, 3'b111, 3'b000,
		3'b100, 3'b100, 3'b100, 3'b000, 3'b000, 3'b100, 3'b100, 3'b001,
		3'b011
	};

	always #6 clk = ~clk;

	button_gesture_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	bgc_gesture_check checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_mon (sample_bus),
		.result_mon (result_bus),
		.cfg_mon    (cfg_bus),
		.fail_count (gesture_fails),
		.owed_count (gestures_owed)
	);

	function automatic cfg_t mk_cfg(input logic ah, input logic [15:0] deb,
		input logic [15:0] win, input logic [15:0] l1, input logic [15:0] l2,
		input logic [15:0] l3, input logic [15:0] l4);
		return '{ah, deb, win, l1, l2, l3, l4};
	endfunction

	function automatic logic pin_for(input bit pressed);
		return knobs.pressed_high ? pressed : !pressed;
	endfunction

	function automatic int capped(input logic [15:0] v);
		return (int'(v) > span_cap) ? span_cap : int'(v);
	endfunction

	task automatic send_tick(input logic pin, input logic clr, input logic wake);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.pin_level <= pin;
		sample_bus.clear_request <= clr;
		sample_bus.wake_press <= wake;
		@(posedge clk);
		while (!sample_bus.ready) @(posedge clk);
		ticks_sent++;
	endtask

	task automatic hold_level(input bit pressed, input int n);
		repeat (n) send_tick(pin_for(pressed), 1'b0, 1'b0);
	endtask

	// stop offering samples and wait until every result transaction is in
	task automatic drain();
		sample_bus.valid <= 1'b0;
		@(posedge clk);
		while (gestures_owed != 0) @(posedge clk);
	endtask

	// leaves valid high so back-to-back writes need no gap
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	task automatic write_config(input cfg_t c);
		drain();
		write_reg(CFG_POLARITY, {15'd0, c.pressed_high});
		write_reg(CFG_DEBOUNCE, c.debounce);
		write_reg(CFG_WINDOW, c.window);
		write_reg(CFG_LONG_ONE, c.long_one);
		write_reg(CFG_LONG_TWO, c.long_two);
		write_reg(CFG_LONG_THREE, c.long_three);
		write_reg(CFG_LONG_FOUR, c.long_four);
		cfg_bus.valid <= 1'b0;
		knobs = c;
	endtask

	// A press sequence: one to four clicks or a long hold, with optional
	// contact bounce, then a quiet tail of the capped window and debounce, and usually a clear.
	task automatic one_gesture();
		int  clicks;
		int  press_len;
		bit  long_hold;
		clicks = $urandom_range(1, 4);
		long_hold = ($urandom_range(0, 3) == 0);
		calm = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0)
			send_tick(pin_for(1'b1), 1'b0, 1'b1);
		for (int c = 0; c < clicks; c++) begin
			if ($urandom_range(0, 3) == 0) begin
				hold_level(1'b1, 1);
				hold_level(1'b0, 1);
			end
			if (long_hold)
				press_len = $urandom_range(capped(knobs.long_one), capped(knobs.long_four) + 3);
			else if ($urandom_range(0, 7) == 0)
				press_len = $urandom_range(1, capped(knobs.debounce) + 1);
			else
				press_len = capped(knobs.debounce) + $urandom_range(1, 4);
			hold_level(1'b1, press_len);
			if (long_hold)
				break;
			if (c < clicks - 1)
				hold_level(1'b0, capped(knobs.debounce) + $urandom_range(1, 6));
		end
		hold_level(1'b0, capped(knobs.window) + capped(knobs.debounce) + $urandom_range(0, 4));
		if ($urandom_range(0, 7) != 0)
			send_tick(pin_for(1'b0), 1'b1, 1'b0);
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 10);
		repeat (n)
			send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0,
				$urandom_range(0, 7) == 0);
	endtask

	task automatic run_phase(input int budget, input int cap);
		int stop_at;
		span_cap = cap;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				noise_burst();
			else
				one_gesture();
		end
		calm = 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
			while (!result_bus.valid) @(posedge clk);
		end
	end

	initial begin
		int cycles_run;
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sample_bus.valid <= 1'b0;
		sample_bus.pin_level <= 1'b0;
		sample_bus.clear_request <= 1'b0;
		sample_bus.wake_press <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_POLARITY;
		cfg_bus.data <= '0;
		arst_n <= 1'b0;
		knobs = mk_cfg(1'b1, RST_DEBOUNCE, RST_WINDOW, RST_LONG_ONE, RST_LONG_TWO,
			RST_LONG_THREE, RST_LONG_FOUR);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values; cap keeps the quiet tail past the 300-tick window
		run_phase(200, 260);

		write_config(mk_cfg(1'b1, 16'd1, 16'd4, 16'd3, 16'd5, 16'd7, 16'd9));
		foreach (opening[i])
			send_tick(opening[i].pin_level, opening[i].clear_request, opening[i].wake_press);

		write_config(mk_cfg(1'b0, 16'd2, 16'd12, 16'd20, 16'd30, 16'd40, 16'd50));
		run_phase(200, 150);
		write_config(mk_cfg(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		run_phase(120, 150);
		// long thresholds out of order
		write_config(mk_cfg(1'b1, 16'd3, 16'd15, 16'd30, 16'd10, 16'd25, 16'd5));
		run_phase(180, 150);
		write_config(mk_cfg(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		run_phase(60, 20);

		// long receiver hold-off while samples keep coming, then a full pause
		write_config(mk_cfg(1'b1, 16'd1, 16'd8, 16'd6, 16'd12, 16'd18, 16'd24));
		hold_request = 1'b1;
		run_phase(120, 150);
		drain();
		run_phase(100, 150);

		write_config(mk_cfg(1'b0, 16'd4, 16'hFFFF, 16'd8, 16'd16, 16'd24, 16'd32));
		run_phase(120, 150);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (gesture_fails == 0 && gestures_owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_if.sv
hw/rtl/bgc_cfg_regs.sv
hw/rtl/bgc_core.sv
hw/rtl/button_gesture_classifier.sv
tb/sv/bgc_gesture_check.sv
tb/sv/tb.sv
